### rtl/prqs_pkg.sv
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types, constants and helpers for the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

  // Sizing of the task pool and of the priority levels
  localparam int NumTasks  = 64;
  localparam int NumLevels = 32;

  // Fixed payload widths
  localparam int TaskW = 6;
  localparam int PrioW = 5;

  // Address widths of the per-level and per-task stores
  localparam int LevelAw = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int TaskAw  = (NumTasks > 1) ? $clog2(NumTasks) : 1;

  // Action codes of an input transaction
  localparam logic ActEnqueue = 1'b0;
  localparam logic ActPick    = 1'b1;

  // Highest set bit of the ready bitmap (zero when the map is empty)
  function automatic logic [LevelAw-1:0] top_level(input logic [NumLevels-1:0] map);
    logic [LevelAw-1:0] res;
    res = '0;
    for (int i = 0; i < NumLevels; i++) begin
      if (map[i]) begin
        res = LevelAw'(i);
      end
    end
    return res;
  endfunction

endpackage

### rtl/priority_ready_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top
// Bitmap-indexed ready queues of task indices, one FIFO per priority level.
// ----------------------------------------------------------------------------
// Each transaction is handled on its own; in_ready_o is high only while the
// sequencer is idle. An enqueue writes head and tail from idle when its level
// is empty and passes through StEnqLink when it appends behind the current
// tail, since the tail RAM read is registered. A nonempty pick runs StIdle,
// StPickChk and StPickOut plus any wait for the output register to free up:
// select the top level and read its head and tail, compare them and read the
// head's next link, then retire the result and write back the new head. An
// empty pick skips the lookup and waits in StPickOut alike; it returns
// found_o = 0, picked_task_o = 0. Enqueuing a task that is already queued is
// not allowed. The head, tail and link stores are not cleared at reset.
module priority_ready_queue_scheduler_top
  import prqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [TaskW-1:0] task_index_i,
  input  logic [PrioW-1:0] priority_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TaskW-1:0] picked_task_o,
  output logic             found_o
);

  // Sequencer states
  localparam int StW = 2;
  localparam logic [StW-1:0] StIdle    = 2'd0;
  localparam logic [StW-1:0] StEnqLink = 2'd1;
  localparam logic [StW-1:0] StPickChk = 2'd2;
  localparam logic [StW-1:0] StPickOut = 2'd3;

  logic [StW-1:0]       state_q, state_d;
  logic [NumLevels-1:0] bitmap_q, bitmap_d;
  logic [TaskW-1:0]     task_q, task_d;
  logic [LevelAw-1:0]   lvl_q, lvl_d;
  logic [TaskW-1:0]     res_task_q, res_task_d;
  logic                 res_found_q, res_found_d;
  logic                 wb_q, wb_d;
  logic                 out_valid_q, out_valid_d;
  logic [TaskW-1:0]     out_task_q, out_task_d;
  logic                 out_found_q, out_found_d;

  // RAM ports
  logic               head_we, head_re, tail_we, tail_re, link_we, link_re;
  logic [LevelAw-1:0] head_waddr, head_raddr, tail_waddr, tail_raddr;
  logic [TaskAw-1:0]  link_waddr, link_raddr;
  logic [TaskW-1:0]   head_wdata, tail_wdata, link_wdata;
  logic [TaskW-1:0]   head_rdata, tail_rdata, link_rdata;

  logic               in_fire;
  logic               in_ok;
  logic [LevelAw-1:0] in_lvl;
  logic               out_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;
  assign in_lvl     = LevelAw'(priority_req_i);
  assign in_ok      = (int'(task_index_i) < NumTasks) && (int'(priority_req_i) < NumLevels);
  assign out_free   = ~out_valid_q | out_ready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    bitmap_d    = bitmap_q;
    task_d      = task_q;
    lvl_d       = lvl_q;
    res_task_d  = res_task_q;
    res_found_d = res_found_q;
    wb_d        = wb_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_task_d  = out_task_q;
    out_found_d = out_found_q;

    head_we = 1'b0; head_waddr = lvl_q; head_wdata = task_q;
    head_re = 1'b0; head_raddr = in_lvl;
    tail_we = 1'b0; tail_waddr = lvl_q; tail_wdata = task_q;
    tail_re = 1'b0; tail_raddr = in_lvl;
    link_we = 1'b0; link_waddr = TaskAw'(tail_rdata); link_wdata = task_q;
    link_re = 1'b0; link_raddr = TaskAw'(head_rdata);

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          task_d = task_index_i;
          lvl_d  = in_lvl;
          if (action_i == ActEnqueue) begin
            // Start a new list, or fetch the tail to append behind it
            if (in_ok) begin
              if (!bitmap_q[in_lvl]) begin
                head_we    = 1'b1;
                head_waddr = in_lvl;
                head_wdata = task_index_i;
                tail_we    = 1'b1;
                tail_waddr = in_lvl;
                tail_wdata = task_index_i;
                bitmap_d[in_lvl] = 1'b1;
              end else begin
                tail_re    = 1'b1;
                tail_raddr = in_lvl;
                state_d    = StEnqLink;
              end
            end
          end else begin
            // Select the top level and read its head and tail
            if (bitmap_q != '0) begin
              lvl_d      = top_level(bitmap_q);
              head_re    = 1'b1;
              head_raddr = top_level(bitmap_q);
              tail_re    = 1'b1;
              tail_raddr = top_level(bitmap_q);
              state_d    = StPickChk;
            end else begin
              res_task_d  = '0;
              res_found_d = 1'b0;
              wb_d        = 1'b0;
              state_d     = StPickOut;
            end
          end
        end
      end
      StEnqLink: begin
        // Link the old tail to the new task and move the tail
        link_we    = 1'b1;
        link_waddr = TaskAw'(tail_rdata);
        link_wdata = task_q;
        tail_we    = 1'b1;
        tail_waddr = lvl_q;
        tail_wdata = task_q;
        state_d    = StIdle;
      end
      StPickChk: begin
        // Pop the head; drop the level bit when it was the last task
        res_task_d  = head_rdata;
        res_found_d = 1'b1;
        if (head_rdata == tail_rdata) begin
          bitmap_d[lvl_q] = 1'b0;
          wb_d            = 1'b0;
        end else begin
          link_re    = 1'b1;
          link_raddr = TaskAw'(head_rdata);
          wb_d       = 1'b1;
        end
        state_d = StPickOut;
      end
      StPickOut: begin
        // Retire the result and advance the head
        if (out_free) begin
          out_valid_d = 1'b1;
          out_task_d  = res_task_q;
          out_found_d = res_found_q;
          if (wb_q) begin
            head_we    = 1'b1;
            head_waddr = lvl_q;
            head_wdata = link_rdata;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bitmap_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bitmap_q    <= bitmap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    task_q      <= task_d;
    lvl_q       <= lvl_d;
    res_task_q  <= res_task_d;
    res_found_q <= res_found_d;
    wb_q        <= wb_d;
    out_task_q  <= out_task_d;
    out_found_q <= out_found_d;
  end

  assign out_valid_o   = out_valid_q;
  assign picked_task_o = out_task_q;
  assign found_o       = out_found_q;

  // Per-level head and tail, per-task next link
  prqs_ram #(.Width(TaskW), .Depth(NumLevels)) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(head_waddr),
    .wdata_i(head_wdata),
    .re_i   (head_re),
    .raddr_i(head_raddr),
    .rdata_o(head_rdata)
  );

  prqs_ram #(.Width(TaskW), .Depth(NumLevels)) u_tail_ram (
    .clk_i  (clk_i),
    .we_i   (tail_we),
    .waddr_i(tail_waddr),
    .wdata_i(tail_wdata),
    .re_i   (tail_re),
    .raddr_i(tail_raddr),
    .rdata_o(tail_rdata)
  );

  prqs_ram #(.Width(TaskW), .Depth(NumTasks)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (link_re),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

endmodule

### rtl/prqs_ram.sv
// ----------------------------------------------------------------------------
// prqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prqs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold the last word when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/prqs_checker.sv
// ----------------------------------------------------------------------------
// prqs_checker
// Port-level checks for the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
module prqs_checker
  import prqs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             action_i,
  input logic [TaskW-1:0] task_index_i,
  input logic [PrioW-1:0] priority_req_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [TaskW-1:0] picked_task_o,
  input logic             found_o
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(picked_task_o) && $stable(found_o))
    else $error("stalled result changed");

  // An empty pick reports task zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> picked_task_o == '0)
    else $error("empty pick with nonzero task");

  // A pick keeps the input side busy at least until its result is staged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ActPick |=> !in_ready_o)
    else $error("pick accepted back to back");

  // An enqueue never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ActEnqueue |=> !$rose(out_valid_o))
    else $error("result after enqueue");

endmodule

bind priority_ready_queue_scheduler_top prqs_checker u_prqs_checker (.*);
